// ===== rtl/core/ftdt_pkg.sv =====
// ftdt_pkg: shared types and constants for fraction_to_decimal_text
// used by the interface file, the controller, the datapath and the top level
`default_nettype none
package ftdt_pkg;
	localparam int unsigned MaxFracDigits = 9;
	localparam int unsigned NumW = 32;
	localparam int unsigned ProdW = 64;
	localparam int unsigned DigW = 5;
	// decimal digits held by the conversion register, enough for 2^31 * 10^9
	localparam int unsigned DecDigits = 19;

	localparam logic [7:0] ChZero = 8'h30;
	localparam logic [7:0] ChPoint = 8'h2e;
	localparam logic [7:0] ChMinus = 8'h2d;

	typedef struct packed {
		logic signed [31:0] numerator;
		logic signed [31:0] denominator;
		logic [3:0] fraction_digits;
	} in_item_t;

	typedef struct packed {
		logic [7:0] text_char;
		logic last_char;
		logic divide_error;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scale_step;
		logic div_init;
		logic div_step;
		logic conv_init;
		logic conv_step;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic den_zero;
		logic num_zero;
		logic scale_done;
		logic div_done;
		logic conv_done;
	} dp_stat_t;
endpackage
`default_nettype wire

// ===== rtl/core/ftdt_if.sv =====
// ftdt_if: valid/ready channel interfaces for input items and result characters
// depends on ftdt_pkg
`default_nettype none
interface ftdt_in_if;
	logic valid;
	logic ready;
	ftdt_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ftdt_out_if;
	logic valid;
	logic ready;
	ftdt_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ftdt_datapath.sv =====
// ftdt_datapath: scaling by ten, restoring divider, shift-and-add-3 decimal conversion
// depends on ftdt_pkg; driven by ftdt_ctrl commands
`default_nettype none
module ftdt_datapath #(
	parameter int unsigned MAX_FRACTION_DIGITS = ftdt_pkg::MaxFracDigits
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire ftdt_pkg::in_item_t in_item,
	input wire ftdt_pkg::dp_cmd_t cmd,
	output ftdt_pkg::dp_stat_t stat,
	input wire logic [ftdt_pkg::DigW-1:0] rd_idx,
	output logic [3:0] rd_digit,
	output logic [ftdt_pkg::DigW-1:0] n_digits,
	output logic [3:0] frac_digits,
	output logic neg
);
	import ftdt_pkg::*;

	logic [ProdW-1:0] prod_q;
	logic [NumW-1:0] dmag_q;
	logic [3:0] scale_cnt_q;
	logic [3:0] fd_q;
	logic neg_q;
	logic [ProdW-1:0] quo_q;
	logic [NumW:0] rem_q;
	logic [6:0] div_cnt_q;
	logic [ProdW-1:0] conv_q;
	logic [6:0] conv_cnt_q;
	logic [4*DecDigits-1:0] bcd_q;

	logic [NumW-1:0] nmag, dmag;
	logic [3:0] fd_sat;
	logic [NumW:0] rem_sh;
	logic rem_ge;
	logic [4*DecDigits-1:0] bcd_adj;
	logic [DigW-1:0] ndig;

	assign nmag = in_item.numerator[NumW-1] ? NumW'(-in_item.numerator) : in_item.numerator;
	assign dmag = in_item.denominator[NumW-1] ? NumW'(-in_item.denominator)
		: in_item.denominator;
	assign fd_sat = (in_item.fraction_digits > 4'(MAX_FRACTION_DIGITS))
		? 4'(MAX_FRACTION_DIGITS) : in_item.fraction_digits;

	assign rem_sh = {rem_q[NumW-1:0], quo_q[ProdW-1]};
	assign rem_ge = rem_sh >= {1'b0, dmag_q};

	// add 3 to every decimal digit of 5 or more before the next shift
	always_comb begin
		for (int k = 0; k < DecDigits; k++) begin
			bcd_adj[4*k +: 4] = (bcd_q[4*k +: 4] >= 4'd5) ? bcd_q[4*k +: 4] + 4'd3
				: bcd_q[4*k +: 4];
		end
	end

	// digit count is the position of the highest nonzero decimal digit
	always_comb begin
		ndig = '0;
		for (int k = 0; k < DecDigits; k++) begin
			if (bcd_q[4*k +: 4] != 4'd0) ndig = DigW'(k + 1);
		end
	end

	always_comb begin
		rd_digit = 4'd0;
		for (int k = 0; k < DecDigits; k++) begin
			if (rd_idx == DigW'(k)) rd_digit = bcd_q[4*k +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_cnt_q <= '0;
			div_cnt_q <= '0;
			conv_cnt_q <= '0;
		end else begin
			if (cmd.load) begin
				scale_cnt_q <= fd_sat;
			end else if (cmd.scale_step && scale_cnt_q != '0) begin
				scale_cnt_q <= scale_cnt_q - 4'd1;
			end
			if (cmd.div_init) begin
				div_cnt_q <= 7'(ProdW);
			end else if (cmd.div_step && div_cnt_q != '0) begin
				div_cnt_q <= div_cnt_q - 7'd1;
			end
			if (cmd.conv_init) begin
				conv_cnt_q <= 7'(ProdW);
			end else if (cmd.conv_step && conv_cnt_q != '0) begin
				conv_cnt_q <= conv_cnt_q - 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			prod_q <= {32'd0, nmag};
			dmag_q <= dmag;
			fd_q <= fd_sat;
			neg_q <= in_item.numerator[NumW-1] ^ in_item.denominator[NumW-1];
		end else if (cmd.scale_step && scale_cnt_q != '0) begin
			prod_q <= (prod_q << 3) + (prod_q << 1);
		end
		if (cmd.div_init) begin
			quo_q <= prod_q;
			rem_q <= '0;
		end else if (cmd.div_step && div_cnt_q != '0) begin
			rem_q <= rem_ge ? rem_sh - {1'b0, dmag_q} : rem_sh;
			quo_q <= {quo_q[ProdW-2:0], rem_ge};
		end
		if (cmd.conv_init) begin
			conv_q <= quo_q;
			bcd_q <= '0;
		end else if (cmd.conv_step && conv_cnt_q != '0) begin
			conv_q <= conv_q << 1;
			bcd_q <= {bcd_adj[4*DecDigits-2:0], conv_q[ProdW-1]};
		end
	end

	assign stat.den_zero = in_item.denominator == '0;
	assign stat.num_zero = in_item.numerator == '0;
	assign stat.scale_done = scale_cnt_q == '0;
	assign stat.div_done = div_cnt_q == '0;
	assign stat.conv_done = conv_cnt_q == '0;

	assign n_digits = ndig;
	assign frac_digits = fd_q;
	assign neg = neg_q;
endmodule
`default_nettype wire

// ===== rtl/core/ftdt_ctrl.sv =====
// ftdt_ctrl: sequencing state machine and character emitter
// depends on ftdt_pkg; commands ftdt_datapath
`default_nettype none
module ftdt_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	output ftdt_pkg::out_item_t out_data,
	output ftdt_pkg::dp_cmd_t cmd,
	input wire ftdt_pkg::dp_stat_t stat,
	output logic [ftdt_pkg::DigW-1:0] rd_idx,
	input wire logic [3:0] rd_digit,
	input wire logic [ftdt_pkg::DigW-1:0] n_digits,
	input wire logic [3:0] frac_digits,
	input wire logic neg
);
	import ftdt_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SCALE = 6'b000010,
		S_DIV = 6'b000100,
		S_CONV = 6'b001000,
		S_EMIT = 6'b010000,
		S_ONE = 6'b100000
	} state_t;

	// emit phase: sign, lead "0.", pad zeros, digits
	typedef enum logic [4:0] {
		P_SIGN = 5'b00001,
		P_LEAD0 = 5'b00010,
		P_LEADPT = 5'b00100,
		P_PAD = 5'b01000,
		P_DIG = 5'b10000
	} phase_t;

	state_t state_q;
	phase_t phase_q;
	logic [DigW-1:0] idx_q;
	logic [DigW-1:0] pad_q;
	logic pt_after_q;
	logic err_q;
	logic vld_q;
	out_item_t data_q;
	logic slot_free;
	logic emit_go;

	assign slot_free = !vld_q || out_ready;
	assign emit_go = (state_q == S_ONE || state_q == S_EMIT) && slot_free;
	assign in_ready = state_q == S_IDLE && slot_free;
	assign out_valid = vld_q;
	assign out_data = data_q;
	assign rd_idx = idx_q - DigW'(1);

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		cmd.scale_step = state_q == S_SCALE;
		cmd.div_init = state_q == S_SCALE && stat.scale_done;
		cmd.div_step = state_q == S_DIV;
		cmd.conv_init = state_q == S_DIV && stat.div_done;
		cmd.conv_step = state_q == S_CONV;
	end

	logic big;
	assign big = n_digits > DigW'(frac_digits);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= P_SIGN;
			vld_q <= 1'b0;
			idx_q <= '0;
			pad_q <= '0;
			pt_after_q <= 1'b0;
			err_q <= 1'b0;
			data_q <= '0;
		end else begin
			if (emit_go) vld_q <= 1'b1;
			else if (out_ready) vld_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						if (stat.den_zero || stat.num_zero) begin
							err_q <= stat.den_zero;
							state_q <= S_ONE;
						end else begin
							state_q <= S_SCALE;
						end
					end
				end
				S_ONE: begin
					if (slot_free) begin
						data_q <= '{text_char: ChZero, last_char: 1'b1, divide_error: err_q};
						state_q <= S_IDLE;
					end
				end
				S_SCALE: if (stat.scale_done) state_q <= S_DIV;
				S_DIV: if (stat.div_done) state_q <= S_CONV;
				S_CONV: begin
					if (stat.conv_done) begin
						state_q <= S_EMIT;
						idx_q <= n_digits;
						pt_after_q <= 1'b0;
						pad_q <= DigW'(frac_digits) - n_digits;
						phase_q <= (neg && n_digits != '0) ? P_SIGN
							: (big ? P_DIG : P_LEAD0);
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						data_q.divide_error <= 1'b0;
						unique case (phase_q)
							P_SIGN: begin
								data_q.text_char <= ChMinus;
								data_q.last_char <= 1'b0;
								phase_q <= big ? P_DIG : P_LEAD0;
							end
							P_LEAD0: begin
								data_q.text_char <= ChZero;
								data_q.last_char <= 1'b0;
								phase_q <= P_LEADPT;
							end
							P_LEADPT: begin
								data_q.text_char <= ChPoint;
								data_q.last_char <= pad_q == '0 && idx_q == '0;
								if (pad_q != '0) phase_q <= P_PAD;
								else if (idx_q != '0) phase_q <= P_DIG;
								else state_q <= S_IDLE;
							end
							P_PAD: begin
								data_q.text_char <= ChZero;
								data_q.last_char <= pad_q == DigW'(1) && idx_q == '0;
								pad_q <= pad_q - DigW'(1);
								if (pad_q == DigW'(1)) begin
									if (idx_q != '0) phase_q <= P_DIG;
									else state_q <= S_IDLE;
								end
							end
							P_DIG: begin
								// point goes after the digit whose index equals frac_digits
								if (big && pt_after_q) begin
									data_q.text_char <= ChPoint;
									data_q.last_char <= idx_q == '0;
									pt_after_q <= 1'b0;
									if (idx_q == '0) state_q <= S_IDLE;
								end else begin
									data_q.text_char <= ChZero | {4'd0, rd_digit};
									idx_q <= idx_q - DigW'(1);
									if (big && rd_idx == DigW'(frac_digits)) begin
										data_q.last_char <= 1'b0;
										pt_after_q <= 1'b1;
									end else begin
										data_q.last_char <= idx_q == DigW'(1);
										if (idx_q == DigW'(1)) state_q <= S_IDLE;
									end
								end
							end
							default: phase_q <= P_SIGN;
						endcase
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == S_IDLE) else $error("ready outside idle");
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && data_q.divide_error |-> data_q.last_char) else $error("error not last");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && !out_ready |=> vld_q && $stable(data_q)) else $error("result dropped");
endmodule
`default_nettype wire

// ===== rtl/core/fraction_to_decimal_text.sv =====
// fraction to decimal text: an accepted transaction passes through scaling by ten,
// the restoring divide, decimal conversion and the output register; fd saturated
// one item at a time, the next accepted only after the last character; one character
// per cycle while the sink is ready; zero numerator or denominator gives a single '0'
// arst_n clears the controller, counters, output valid and data, not the datapath operands.
// depends on ftdt_pkg, ftdt_if, ftdt_ctrl, ftdt_datapath
`default_nettype none
module fraction_to_decimal_text #(
	parameter int unsigned MAX_FRACTION_DIGITS = ftdt_pkg::MaxFracDigits
) (
	input wire logic clk,
	input wire logic arst_n,
	ftdt_in_if.sink in_ch,
	ftdt_out_if.source out_ch
);
	import ftdt_pkg::*;

	dp_cmd_t cmd;
	dp_stat_t stat;
	logic [DigW-1:0] rd_idx, n_digits;
	logic [3:0] rd_digit, frac_digits;
	logic neg;

	ftdt_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
		.cmd, .stat, .rd_idx, .rd_digit, .n_digits, .frac_digits, .neg
	);

	ftdt_datapath #(.MAX_FRACTION_DIGITS(MAX_FRACTION_DIGITS)) u_dp (
		.clk, .arst_n, .in_item(in_ch.data),
		.cmd, .stat, .rd_idx, .rd_digit, .n_digits, .frac_digits, .neg
	);
endmodule
`default_nettype wire
